### rtl/mcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcw_pkg;

  localparam int WheelSlots = 4;
  localparam int NumWheels  = 4;
  localparam int Channels   = 2 * WheelSlots;
  localparam int DutyW      = 12;
  localparam int DutyMax    = 4095;
  localparam int ChanLimit  = 4095;
  localparam int SpeedLimit = 100;
  localparam int MagW       = 7;

  localparam int     DutyShift  = 16;
  localparam longint DutyRecipL = (longint'(DutyMax) * (longint'(1) << DutyShift) + 99) / 100;
  localparam int     DutyRecipW = $clog2(DutyRecipL + 1);
  localparam logic [DutyRecipW-1:0] DutyRecip = DutyRecipW'(DutyRecipL);
  localparam int     DutyProdW  = MagW + DutyRecipW;

  localparam logic [15:0] DefaultTtlReset = 16'd500;
  localparam logic [15:0] MaxTtlReset     = 16'd1000;

  localparam int InDataW  = 104;
  localparam int OutDataW = 184;

  typedef enum logic [1:0] {
    REQ_DRIVE = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_STOP  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_APPLIED      = 2'd0,
    ST_NOT_READY    = 2'd1,
    ST_OUT_OF_ORDER = 2'd2,
    ST_NO_COMMAND   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_DRIVER_READY = 2'd0,
    CFG_DEFAULT_TTL  = 2'd1,
    CFG_MAX_TTL      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic        driver_ready;
    logic [15:0] default_ttl_ms;
    logic [15:0] max_ttl_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                   req_type;
    logic [WheelSlots-1:0][7:0]   speed;
    logic [31:0]                  sequence_number;
    logic [31:0]                  ttl_request_ms;
    logic                         enforce_order;
  } item_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic [15:0]                  applied_ttl_ms;
    logic [31:0]                  last_sequence;
    logic [31:0]                  command_age_ms;
    logic [Channels-1:0][DutyW-1:0] duty;
  } result_t;

endpackage

`default_nettype wire

### rtl/motor_command_watchdog_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Motor command watchdog for a four-wheel H-bridge drive.
// Requests enter on the s_ group: s_tuser carries the request kind (drive,
// millisecond tick, stop all) and s_tdata the wheel speeds, sequence number,
// requested time to live and the ordering flag. Every request yields exactly
// one result on the m_ group: status, time to live in force, last sequence
// number, command age and the eight channel duties after that request.
// Settings are written through cfg_write/cfg_index/cfg_data; the user must
// write them only while no request is in flight; the block does not enforce it.
// Each request is held in the input register and its result in the result
// register. Throughput: one request per cycle while m_tready does not stall
// the result register; the state update is a single pass through the clamp,
// reciprocal multiply and compare logic between those two registers.
// Reset clears all counters, duties and the sequence record, sets the time
// to live to 500 ms, the driver to not ready and the maximum to 1000 ms.
// When m_tready is low the result register holds and one more request can
// wait in the input register; s_tready drops only when both are full.
module motor_command_watchdog_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // [7:0] speed_front_left, [15:8] speed_front_right, [23:16] speed_rear_left,
  // [31:24] speed_rear_right, [63:32] sequence_number, [95:64] ttl_request_ms,
  // [96] enforce_order, [103:97] zero
  input  wire logic [mcw_pkg::InDataW-1:0]   s_tdata,
  // [1:0] req_type
  input  wire logic [1:0]                    s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [1:0] status, [17:2] applied_ttl_ms, [49:18] last_sequence,
  // [81:50] command_age_ms, [93:82] fl_forward_duty, [105:94] fl_reverse_duty,
  // [117:106] fr_forward_duty, [129:118] fr_reverse_duty,
  // [141:130] rl_forward_duty, [153:142] rl_reverse_duty,
  // [165:154] rr_forward_duty, [177:166] rr_reverse_duty, [183:178] zero
  output logic [mcw_pkg::OutDataW-1:0]       m_tdata,
  input  wire logic                          cfg_write,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [15:0]                   cfg_data
);

  mcw_pkg::cfg_t    cfg;
  mcw_pkg::item_t   in_item;
  mcw_pkg::result_t result;
  logic             in_valid;
  logic             advance;
  logic             load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.driver_ready   <= 1'b0;
      cfg.default_ttl_ms <= mcw_pkg::DefaultTtlReset;
      cfg.max_ttl_ms     <= mcw_pkg::MaxTtlReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mcw_pkg::CFG_DRIVER_READY: cfg.driver_ready   <= cfg_data[0];
        mcw_pkg::CFG_DEFAULT_TTL:  cfg.default_ttl_ms <= cfg_data;
        mcw_pkg::CFG_MAX_TTL:      cfg.max_ttl_ms     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign advance  = !m_tvalid || m_tready;
  assign load     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.req_type        <= s_tuser;
      in_item.speed[0]        <= s_tdata[7:0];
      in_item.speed[1]        <= s_tdata[15:8];
      in_item.speed[2]        <= s_tdata[23:16];
      in_item.speed[3]        <= s_tdata[31:24];
      in_item.sequence_number <= s_tdata[63:32];
      in_item.ttl_request_ms  <= s_tdata[95:64];
      in_item.enforce_order   <= s_tdata[96];
    end
  end

  mcw_state u_state (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .cfg    (cfg),
    .item   (in_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {6'd0,
                  result.duty[7], result.duty[6], result.duty[5], result.duty[4],
                  result.duty[3], result.duty[2], result.duty[1], result.duty[0],
                  result.command_age_ms, result.last_sequence,
                  result.applied_ttl_ms, result.status};
    end
  end

endmodule

`default_nettype wire

### rtl/mcw_wheel.sv
`timescale 1ns / 1ps
`default_nettype none

module mcw_wheel (
  input  wire logic [7:0]               speed,
  output logic [mcw_pkg::DutyW-1:0]     forward_duty,
  output logic [mcw_pkg::DutyW-1:0]     reverse_duty
);

  logic signed [7:0]               speed_s;
  logic [mcw_pkg::MagW-1:0]        mag;
  logic [mcw_pkg::DutyProdW-1:0]   prod;
  logic [mcw_pkg::DutyProdW-1:0]   quot;
  logic [mcw_pkg::DutyW-1:0]       duty;

  assign speed_s = $signed(speed);

  always_comb begin
    if (speed_s > 8'sd100) begin
      mag = mcw_pkg::MagW'(mcw_pkg::SpeedLimit);
    end else if (speed_s < -8'sd100) begin
      mag = mcw_pkg::MagW'(mcw_pkg::SpeedLimit);
    end else if (speed_s < 8'sd0) begin
      mag = mcw_pkg::MagW'(-speed_s);
    end else begin
      mag = speed_s[mcw_pkg::MagW-1:0];
    end
  end

  // scale by DutyMax/100 through a scaled reciprocal
  assign prod = mcw_pkg::DutyProdW'(mag) * mcw_pkg::DutyProdW'(mcw_pkg::DutyRecip);
  assign quot = prod >> mcw_pkg::DutyShift;

  always_comb begin
    if (quot > mcw_pkg::DutyProdW'(mcw_pkg::ChanLimit)) begin
      duty = mcw_pkg::DutyW'(mcw_pkg::ChanLimit);
    end else begin
      duty = quot[mcw_pkg::DutyW-1:0];
    end
  end

  assign forward_duty = (speed_s > 8'sd0) ? duty : '0;
  assign reverse_duty = (speed_s < 8'sd0) ? duty : '0;

endmodule

`default_nettype wire

### rtl/mcw_state.sv
`timescale 1ns / 1ps
`default_nettype none

module mcw_state (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire mcw_pkg::cfg_t    cfg,
  input  wire mcw_pkg::item_t   item,
  output mcw_pkg::result_t      result
);

  logic [15:0] remaining;
  logic [15:0] watchdog;
  logic [31:0] last_seq;
  logic [31:0] age;
  logic        active;
  logic [mcw_pkg::Channels-1:0][mcw_pkg::DutyW-1:0] duty;

  logic [15:0] remaining_next;
  logic [15:0] watchdog_next;
  logic [31:0] last_seq_next;
  logic [31:0] age_next;
  logic        active_next;
  logic [mcw_pkg::Channels-1:0][mcw_pkg::DutyW-1:0] duty_next;
  mcw_pkg::status_t status;

  logic [mcw_pkg::Channels-1:0][mcw_pkg::DutyW-1:0] drive_duty;
  logic        drive_any;
  logic [31:0] ttl_sel;
  logic [15:0] ttl_applied;
  logic [15:0] remaining_dec;
  logic        stale;

  for (genvar w = 0; w < mcw_pkg::WheelSlots; w++) begin : g_wheel
    if (w < mcw_pkg::NumWheels) begin : g_on
      mcw_wheel u_wheel (
        .speed        (item.speed[w]),
        .forward_duty (drive_duty[2*w]),
        .reverse_duty (drive_duty[2*w+1])
      );
    end else begin : g_off
      assign drive_duty[2*w]   = '0;
      assign drive_duty[2*w+1] = '0;
    end
  end

  always_comb begin
    drive_any = 1'b0;
    for (int w = 0; w < mcw_pkg::WheelSlots; w++) begin
      if (w < mcw_pkg::NumWheels && item.speed[w] != 8'd0) begin
        drive_any = 1'b1;
      end
    end
  end

  assign ttl_sel = (item.ttl_request_ms == 32'd0) ? {16'd0, cfg.default_ttl_ms}
                                                  : item.ttl_request_ms;
  assign ttl_applied = (ttl_sel > {16'd0, cfg.max_ttl_ms}) ? cfg.max_ttl_ms : ttl_sel[15:0];
  assign remaining_dec = (remaining == 16'd0) ? 16'd0 : remaining - 16'd1;
  assign stale = item.enforce_order && item.sequence_number != 32'd0 &&
                 last_seq != 32'd0 && item.sequence_number <= last_seq;

  always_comb begin
    remaining_next = remaining;
    watchdog_next  = watchdog;
    last_seq_next  = last_seq;
    age_next       = age;
    active_next    = active;
    duty_next      = duty;
    status         = mcw_pkg::ST_NO_COMMAND;
    case (item.req_type)
      mcw_pkg::REQ_DRIVE: begin
        if (!cfg.driver_ready) begin
          status = mcw_pkg::ST_NOT_READY;
        end else if (stale) begin
          status = mcw_pkg::ST_OUT_OF_ORDER;
        end else begin
          watchdog_next  = ttl_applied;
          remaining_next = ttl_applied;
          age_next       = '0;
          if (item.sequence_number != 32'd0) begin
            last_seq_next = item.sequence_number;
          end
          duty_next   = drive_duty;
          active_next = drive_any;
          status      = mcw_pkg::ST_APPLIED;
        end
      end
      mcw_pkg::REQ_TICK: begin
        remaining_next = remaining_dec;
        if (age != 32'hFFFF_FFFF) begin
          age_next = age + 32'd1;
        end
        if (remaining_dec == 16'd0 && active && cfg.driver_ready) begin
          duty_next   = '0;
          active_next = 1'b0;
        end
      end
      mcw_pkg::REQ_STOP: begin
        if (cfg.driver_ready) begin
          duty_next   = '0;
          active_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      watchdog  <= mcw_pkg::DefaultTtlReset;
      last_seq  <= '0;
      age       <= '0;
      active    <= 1'b0;
      duty      <= '0;
    end else if (load) begin
      remaining <= remaining_next;
      watchdog  <= watchdog_next;
      last_seq  <= last_seq_next;
      age       <= age_next;
      active    <= active_next;
      duty      <= duty_next;
    end
  end

  always_comb begin
    result.status         = status;
    result.applied_ttl_ms = watchdog_next;
    result.last_sequence  = last_seq_next;
    result.command_age_ms = age_next;
    result.duty           = duty_next;
  end

endmodule

`default_nettype wire
